// ----- sv/sample_set_statistics_top_assert.svh -----
// assertion macros for the sample set statistics block
// used by sample_set_statistics_top; needs clk and rst_n in scope
`ifndef SAMPLE_SET_STATISTICS_TOP_ASSERT_SVH
`define SAMPLE_SET_STATISTICS_TOP_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define SSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sss check failed: lbl");

// antecedent holds -> consequent holds in the next cycle
`define SSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sss check failed: lbl");

`endif

// ----- sv/sss_pkg.sv -----
// shared types and constants for the sample set statistics block
// no dependencies
package sss_pkg;

    localparam int SAMPLE_PORT_W = 24;
    localparam int COUNT_PORT_W  = 9;
    localparam int STAT_PORT_W   = 32;
    localparam int CAP_W         = 9;
    localparam int FRAC_BITS     = 8;
    localparam int ADDR_W        = 2;

    localparam logic [CAP_W-1:0]  CAP_RESET     = 9'd256;
    localparam logic [ADDR_W-1:0] REG_CAPACITY  = 2'd0;

    // per-cycle command to every cell of the sort chain
    typedef struct packed {
        logic insert;   // broadcast sample is placed into the sorted row
        logic drain;    // row moves one place toward cell 0
    } cell_ctl_t;

endpackage

// ----- sv/sample_set_statistics_top.sv -----
// sample set statistics: sort chain, running sums, shared divider and root
// depends on sss_pkg, sss_cell, sss_div, sss_sqrt, sample_set_statistics_top_assert.svh
//
// usage
//   input channel (in_valid/in_ready): one beat per sample, last closes the set
//   output channel (out_valid/out_ready): one beat per closed set with count,
//     min, max, mean and deviation (24.8 fixed point, floor) and the median
//   capacity register at byte address 0 over the apb port, write it while idle
// throughput
//   samples of an open set are taken one per cycle; each one within the
//   capacity is placed into the sorted row of cells in the cycle it is accepted
// finishing a set
//   after the beat marked last the block stops taking samples while it finishes:
//   the products are formed in S_MUL, then one divider pass for the mean, one for
//   the variance and a root pass, the divider being QW = 2*SAMPLE_BITS +
//   2*clog2(MAX_SAMPLES+1) + 16 bits wide; a set of one sample or none skips the
//   variance and root passes; the median walk runs alongside and does not
//   dominate at default sizes
// reset
//   clears the set and the output beat, capacity returns to 256; the sort row
//   needs no clearing since only the kept entries are ever looked at
// stall
//   a waiting result sits in the output register; the next set is collected
//   while it waits, and only a later result is held back until it is taken
module sample_set_statistics_top #(
    parameter int MAX_SAMPLES = 256,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sss_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // sample channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sss_pkg::SAMPLE_PORT_W-1:0]   sample,
    input  logic                                last,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sss_pkg::COUNT_PORT_W-1:0]    count,
    output logic [sss_pkg::SAMPLE_PORT_W-1:0]   minimum,
    output logic [sss_pkg::SAMPLE_PORT_W-1:0]   maximum,
    output logic [sss_pkg::STAT_PORT_W-1:0]     mean,
    output logic [sss_pkg::STAT_PORT_W-1:0]     deviation,
    output logic [sss_pkg::SAMPLE_PORT_W-1:0]   middle,
    output logic                                dropped
);

    localparam int SB   = SAMPLE_BITS;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int LIMW = (CW > sss_pkg::CAP_W) ? CW : sss_pkg::CAP_W;
    localparam int SUMW = SB + CW;
    localparam int SQW  = 2 * SB + CW;
    localparam int NW   = 2 * SB + 2 * CW;
    localparam int QW   = NW + 16;          // always even
    localparam int DW   = 2 * CW;
    localparam int RW   = QW / 2;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_MUL,
        S_MEAN,
        S_DEV,
        S_ROOT,
        S_OUT
    } state_t;

    state_t                    state_reg;
    logic [sss_pkg::CAP_W-1:0] cap_reg;
    logic [CW-1:0]             count_reg;
    logic [SB-1:0]             min_reg;
    logic [SB-1:0]             max_reg;
    logic [SUMW-1:0]           sum_reg;
    logic [SQW-1:0]            sq_reg;
    logic                      ovf_reg;
    logic [CW-1:0]             drain_reg;
    logic [NW-1:0]             p1_reg;
    logic [NW-1:0]             p2_reg;
    logic [DW-1:0]             nn_reg;
    logic [31:0]               mean_reg;

    // output beat
    logic                             out_valid_reg;
    logic [sss_pkg::COUNT_PORT_W-1:0] count_reg_o;
    logic [SB-1:0]                    min_reg_o;
    logic [SB-1:0]                    max_reg_o;
    logic [31:0]                      mean_reg_o;
    logic [31:0]                      dev_reg_o;
    logic [SB-1:0]                    mid_reg_o;
    logic                             drop_reg_o;

    logic [SB-1:0]       s;
    logic                in_fire;
    logic                keep;
    logic [LIMW-1:0]     limit;
    logic                first;
    logic [CW-1:0]       count_next;
    sss_pkg::cell_ctl_t  ctl;
    logic                cfg_wr;

    logic [SB-1:0] val [MAX_SAMPLES];
    logic          gt  [MAX_SAMPLES];

    logic          div_start;
    logic [QW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic          div_done;
    logic [QW-1:0] div_q;
    logic          sqrt_start;
    logic          sqrt_done;
    logic [RW-1:0] sqrt_root;
    logic          out_load;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == sss_pkg::REG_CAPACITY);
    assign prdata = (paddr == sss_pkg::REG_CAPACITY) ? 32'(cap_reg) : '0;

    // ---------------- sample intake ----------------
    assign s        = sample[SB-1:0];
    assign in_ready = (state_reg == S_COLLECT);
    assign in_fire  = in_valid && in_ready;
    // effective capacity is clipped to the number of cells
    assign limit    = (LIMW'(cap_reg) > LIMW'(MAX_SAMPLES)) ? LIMW'(MAX_SAMPLES)
                                                           : LIMW'(cap_reg);
    assign keep       = LIMW'(count_reg) < limit;
    assign first      = (count_reg == '0);
    assign count_next = count_reg + 1'b1;

    // median walk shifts the row toward cell 0 while the arithmetic runs
    assign ctl.insert = in_fire && keep;
    assign ctl.drain  = (state_reg != S_COLLECT) && (state_reg != S_MUL)
                        && (drain_reg != '0);

    // ---------------- sort chain ----------------
    for (genvar i = 0; i < MAX_SAMPLES; i++)
    begin : g_cell
        logic [SB-1:0] pv;
        logic          pg;
        logic [SB-1:0] nv;
        if (i == 0)
        begin : g_head
            assign pv = '0;
            assign pg = 1'b0;
        end
        else
        begin : g_body
            assign pv = val[i-1];
            assign pg = gt[i-1];
        end
        if (i == MAX_SAMPLES - 1)
        begin : g_tail
            assign nv = '0;
        end
        else
        begin : g_link
            assign nv = val[i+1];
        end
        sss_cell #(
            .SB    (SB),
            .CW    (CW),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .s        (s),
            .count    (count_reg),
            .prev_val (pv),
            .prev_gt  (pg),
            .next_val (nv),
            .val      (val[i]),
            .gt       (gt[i])
        );
    end

    // ---------------- shared divider and root ----------------
    // mean pass first, then the variance pass
    assign div_start    = (state_reg == S_MUL) || ((state_reg == S_MEAN) && div_done
                                                   && (count_reg > CW'(1)));
    assign div_dividend = (state_reg == S_MUL) ? (QW'(sum_reg) << sss_pkg::FRAC_BITS)
                                               : (QW'(p1_reg - p2_reg) << 16);
    assign div_divisor  = (state_reg == S_MUL) ? DW'(count_reg) : nn_reg;
    assign sqrt_start   = (state_reg == S_DEV) && div_done;

    sss_div #(
        .W  (QW),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    sss_sqrt #(
        .RW (RW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_q),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign out_load = (state_reg == S_OUT) && (drain_reg == '0)
                      && (!out_valid_reg || out_ready);

    // ---------------- control and registered outputs ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_COLLECT;
            cap_reg       <= sss_pkg::CAP_RESET;
            count_reg     <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            ovf_reg       <= 1'b0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                cap_reg <= pwdata[sss_pkg::CAP_W-1:0];
            // a beat taken while the next one loads keeps valid high
            if (out_valid && out_ready && !out_load)
                out_valid_reg <= 1'b0;
            if (ctl.drain)
                drain_reg <= drain_reg - 1'b1;

            case (state_reg)
                S_COLLECT:
                begin
                    if (in_fire)
                    begin
                        if (keep)
                        begin
                            if (first || s < min_reg)
                                min_reg <= s;
                            if (first || s > max_reg)
                                max_reg <= s;
                            sum_reg   <= sum_reg + SUMW'(s);
                            sq_reg    <= sq_reg + SQW'(s) * SQW'(s);
                            count_reg <= count_next;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (last)
                            state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    p1_reg    <= NW'(count_reg) * NW'(sq_reg);
                    p2_reg    <= NW'(sum_reg) * NW'(sum_reg);
                    nn_reg    <= DW'(count_reg) * DW'(count_reg - 1'b1);
                    drain_reg <= first ? '0 : ((count_reg - 1'b1) >> 1);
                    state_reg <= S_MEAN;
                end
                S_MEAN:
                begin
                    if (div_done)
                    begin
                        mean_reg <= first ? '0 : 32'(div_q);
                        if (count_reg > CW'(1))
                        begin
                            state_reg <= S_DEV;
                        end
                        else
                        begin
                            dev_reg_o <= '0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_DEV:
                begin
                    if (div_done)
                        state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (sqrt_done)
                    begin
                        dev_reg_o <= 32'(sqrt_root);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        count_reg_o   <= sss_pkg::COUNT_PORT_W'(count_reg);
                        min_reg_o     <= first ? '0 : min_reg;
                        max_reg_o     <= first ? '0 : max_reg;
                        mean_reg_o    <= mean_reg;
                        mid_reg_o     <= first ? '0 : val[0];
                        drop_reg_o    <= ovf_reg;
                        // open the next set
                        count_reg     <= '0;
                        min_reg       <= '0;
                        max_reg       <= '0;
                        sum_reg       <= '0;
                        sq_reg        <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= S_COLLECT;
                    end
                end
                default:
                begin
                    state_reg <= S_COLLECT;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign count     = count_reg_o;
    assign minimum   = sss_pkg::SAMPLE_PORT_W'(min_reg_o);
    assign maximum   = sss_pkg::SAMPLE_PORT_W'(max_reg_o);
    assign mean      = mean_reg_o;
    assign deviation = dev_reg_o;
    assign middle    = sss_pkg::SAMPLE_PORT_W'(mid_reg_o);
    assign dropped   = drop_reg_o;

    // ---------------- checks ----------------
`include "sample_set_statistics_top_assert.svh"

    `SSS_ASSERT_IMP(a_count_bound, 1'b1, LIMW'(count_reg) <= LIMW'(MAX_SAMPLES))
    `SSS_ASSERT_IMP(a_min_le_max, count_reg != '0, min_reg <= max_reg)
    `SSS_ASSERT_NEXT(a_close_stops_intake, in_fire && last, !in_ready)

endmodule

// ----- sv/sss_cell.sv -----
// one cell of the insertion sort chain
// depends on sss_pkg
module sss_cell #(
    parameter int SB    = 24,
    parameter int CW    = 9,
    parameter int INDEX = 0
) (
    input  logic                 clk,
    input  sss_pkg::cell_ctl_t   ctl,
    input  logic [SB-1:0]        s,
    input  logic [CW-1:0]        count,
    input  logic [SB-1:0]        prev_val,
    input  logic                 prev_gt,
    input  logic [SB-1:0]        next_val,
    output logic [SB-1:0]        val,
    output logic                 gt
);

    logic [SB-1:0] val_reg;

    // empty cells count as larger than any sample
    assign gt  = (CW'(INDEX) >= count) || (val_reg > s);
    assign val = val_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.insert)
        begin
            if (prev_gt)
                val_reg <= prev_val;
            else if (gt)
                val_reg <= s;
        end
        else if (ctl.drain)
        begin
            val_reg <= next_val;
        end
    end

endmodule

// ----- sv/sss_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on nothing
module sss_div #(
    parameter int W  = 82,
    parameter int DW = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [W-1:0]  quotient
);

    localparam int CNTW = $clog2(W + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   dsr_reg;
    logic [W-1:0]    quo_reg;
    logic [DW:0]     rem_sh;
    logic            ge;
    logic [DW-1:0]   rem_next;

    assign rem_sh   = {rem_reg, quo_reg[W-1]};
    assign ge       = rem_sh >= {1'b0, dsr_reg};
    assign rem_next = ge ? DW'(rem_sh - {1'b0, dsr_reg}) : DW'(rem_sh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/sss_sqrt.sv -----
// digit-by-digit integer square root, one root bit per cycle
// depends on nothing
module sss_sqrt #(
    parameter int RW = 41
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] radicand,
    output logic            done,
    output logic [RW-1:0]   root
);

    localparam int CNTW = $clog2(RW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [2*RW-1:0] x_reg;
    logic [RW-1:0]   root_reg;
    logic [RW:0]     rem_reg;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic            ge;

    assign rem_sh = {rem_reg, x_reg[2*RW-1:2*RW-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[2*RW-3:0], 2'b00};
            root_reg <= {root_reg[RW-2:0], ge};
            rem_reg  <= ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
